### sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/jtwf_pkg.sv
`default_nettype none

package jtwf_pkg;

  localparam int CP_W      = 21;
  localparam int BASE_W    = 16;
  localparam int RES_DEPTH = 4;

  localparam logic [1:0] REG_FOLD_DIGITS    = 2'd0;
  localparam logic [1:0] REG_FOLD_HALFWIDTH = 2'd1;
  localparam logic [1:0] REG_COMPOSE_ONLY   = 2'd2;

  localparam logic [CP_W-1:0] CP_HIRA_LO    = 21'h003041;
  localparam logic [CP_W-1:0] CP_HIRA_HI    = 21'h003096;
  localparam logic [CP_W-1:0] CP_HIRA_SHIFT = 21'h000060;
  localparam logic [CP_W-1:0] CP_FWA_LO     = 21'h00FF01;
  localparam logic [CP_W-1:0] CP_FWA_HI     = 21'h00FF5E;
  localparam logic [CP_W-1:0] CP_FWD_LO     = 21'h00FF10;
  localparam logic [CP_W-1:0] CP_FWD_HI     = 21'h00FF19;
  localparam logic [CP_W-1:0] CP_FWA_SHIFT  = 21'h00FEE0;
  localparam logic [CP_W-1:0] CP_IDEO_SPACE = 21'h003000;
  localparam logic [CP_W-1:0] CP_SPACE      = 21'h000020;
  localparam logic [CP_W-1:0] CP_HW_LO      = 21'h00FF61;
  localparam logic [CP_W-1:0] CP_HW_BASE_LO = 21'h00FF66;
  localparam logic [CP_W-1:0] CP_HW_HI      = 21'h00FF9D;
  localparam logic [CP_W-1:0] CP_HW_VOICED  = 21'h00FF9E;
  localparam logic [CP_W-1:0] CP_HW_SEMI    = 21'h00FF9F;
  localparam logic [CP_W-1:0] CP_MARK_VOICED = 21'h00309B;
  localparam logic [CP_W-1:0] CP_MARK_SEMI  = 21'h00309C;
  localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_REPLACE    = 21'h00FFFD;

  localparam logic [BASE_W-1:0] HALF_PAGE   = 16'hFF00;
  localparam logic [BASE_W-1:0] HALF_LO     = 16'hFF61;
  localparam logic [BASE_W-1:0] HALF_HI     = 16'hFF9D;
  localparam logic [BASE_W-1:0] KATA_U      = 16'h30A6;
  localparam logic [BASE_W-1:0] KATA_VU     = 16'h30F4;
  localparam logic [BASE_W-1:0] KATA_KA     = 16'h30AB;
  localparam logic [BASE_W-1:0] KATA_DI     = 16'h30C2;
  localparam logic [BASE_W-1:0] KATA_TSU    = 16'h30C4;
  localparam logic [BASE_W-1:0] KATA_DO     = 16'h30C9;
  localparam logic [BASE_W-1:0] KATA_HA     = 16'h30CF;
  localparam logic [BASE_W-1:0] KATA_HI     = 16'h30D2;
  localparam logic [BASE_W-1:0] KATA_HU     = 16'h30D5;
  localparam logic [BASE_W-1:0] KATA_HE     = 16'h30D8;
  localparam logic [BASE_W-1:0] KATA_HO     = 16'h30DB;

  localparam logic [BASE_W-1:0] HALF_FULL [0:63] = '{
    16'h3002, 16'h300C, 16'h300D, 16'h3001, 16'h30FB, 16'h30F2, 16'h30A1, 16'h30A3,
    16'h30A5, 16'h30A7, 16'h30A9, 16'h30E3, 16'h30E5, 16'h30E7, 16'h30C3, 16'h30FC,
    16'h30A2, 16'h30A4, 16'h30A6, 16'h30A8, 16'h30AA, 16'h30AB, 16'h30AD, 16'h30AF,
    16'h30B1, 16'h30B3, 16'h30B5, 16'h30B7, 16'h30B9, 16'h30BB, 16'h30BD, 16'h30BF,
    16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8, 16'h30CA, 16'h30CB, 16'h30CC, 16'h30CD,
    16'h30CE, 16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8, 16'h30DB, 16'h30DE, 16'h30DF,
    16'h30E0, 16'h30E1, 16'h30E2, 16'h30E4, 16'h30E6, 16'h30E8, 16'h30E9, 16'h30EA,
    16'h30EB, 16'h30EC, 16'h30ED, 16'h30EF, 16'h30F3, 16'h0000, 16'h0000, 16'h0000
  };

  typedef struct packed {
    logic fold_digits;
    logic fold_halfwidth;
    logic compose_only;
  } cfg_t;

  typedef struct packed {
    logic [CP_W-1:0] point;
    logic            final_flag;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } res_pair_t;

  function automatic logic [BASE_W-1:0] widen(input logic [BASE_W-1:0] h);
    logic [BASE_W-1:0] offset;
    offset = h - HALF_LO;
    if (h < HALF_LO || h > HALF_HI) begin
      return '0;
    end
    return HALF_FULL[offset[5:0]];
  endfunction

  function automatic logic is_h_row(input logic [BASE_W-1:0] b);
    return b == KATA_HA || b == KATA_HI || b == KATA_HU || b == KATA_HE || b == KATA_HO;
  endfunction

  function automatic logic [BASE_W-1:0] voiced(input logic [BASE_W-1:0] b);
    if (b == KATA_U) begin
      return KATA_VU;
    end
    if (b >= KATA_KA && b <= KATA_DI && b[0]) begin
      return b + 16'd1;
    end
    if (b >= KATA_TSU && b <= KATA_DO && !b[0]) begin
      return b + 16'd1;
    end
    if (is_h_row(b)) begin
      return b + 16'd1;
    end
    return '0;
  endfunction

  function automatic logic [BASE_W-1:0] semi_voiced(input logic [BASE_W-1:0] b);
    if (is_h_row(b)) begin
      return b + 16'd2;
    end
    return '0;
  endfunction

  function automatic logic voiceable(input logic [BASE_W-1:0] b);
    return voiced(b) != '0 || semi_voiced(b) != '0;
  endfunction

  function automatic logic [CP_W-1:0] clamp(input logic [CP_W-1:0] v);
    return (v > CP_MAX) ? CP_REPLACE : v;
  endfunction

endpackage

`default_nettype wire

### sv/jtwf_in_stage.sv
`default_nettype none

module jtwf_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [jtwf_pkg::CP_W-1:0] in_point,
  input  wire logic                      in_final,
  input  wire logic                      take,
  output logic                           item_valid,
  output logic [jtwf_pkg::CP_W-1:0]      item_point,
  output logic                           item_final
);
  import jtwf_pkg::*;

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_point <= in_point;
      item_final <= in_final;
    end
  end

endmodule

`default_nettype wire

### sv/jtwf_fold.sv
`default_nettype none
`include "assert_macros.svh"

module jtwf_fold (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire jtwf_pkg::cfg_t            cfg,
  input  wire logic [jtwf_pkg::CP_W-1:0] item_point,
  input  wire logic                      item_final,
  input  wire logic                      fire,
  output jtwf_pkg::res_pair_t            pair
);
  import jtwf_pkg::*;

  logic              held_valid;
  logic [BASE_W-1:0] held_base;
  logic              held_valid_next;
  logic [BASE_W-1:0] held_base_next;

  always_comb begin
    logic [BASE_W-1:0] base;
    logic [BASE_W-1:0] comp;
    logic [BASE_W-1:0] wide;
    logic              composed;
    logic              flush;
    logic              hold_new;
    logic              in_half;
    logic              digit;
    logic [CP_W-1:0]   r;
    res_t              main_res;
    res_t              flush_res;

    base = (held_base >= HALF_PAGE) ? widen(held_base) : held_base;
    if (item_point == CP_HW_VOICED) begin
      comp = voiced(base);
    end else if (item_point == CP_HW_SEMI) begin
      comp = semi_voiced(base);
    end else begin
      comp = '0;
    end
    composed = held_valid && comp != '0;
    flush    = held_valid && !composed;

    in_half  = item_point >= CP_HW_LO && item_point <= CP_HW_HI;
    wide     = in_half ? widen(item_point[BASE_W-1:0]) : '0;
    digit    = item_point >= CP_FWD_LO && item_point <= CP_FWD_HI;
    hold_new = 1'b0;
    r        = item_point;

    if (cfg.compose_only) begin
      hold_new = item_point >= CP_HW_BASE_LO && item_point <= CP_HW_HI &&
                 voiceable(wide) && !item_final;
    end else if (item_point >= CP_HIRA_LO && item_point <= CP_HIRA_HI) begin
      r = item_point + CP_HIRA_SHIFT;
    end else if (item_point >= CP_FWA_LO && item_point <= CP_FWA_HI) begin
      if (!digit || cfg.fold_digits) begin
        r = item_point - CP_FWA_SHIFT;
      end
    end else if (item_point == CP_IDEO_SPACE) begin
      r = CP_SPACE;
    end else if (cfg.fold_halfwidth && in_half) begin
      r        = {{(CP_W-BASE_W){1'b0}}, wide};
      hold_new = voiceable(wide) && !item_final;
    end else if (cfg.fold_halfwidth && item_point == CP_HW_VOICED) begin
      r = CP_MARK_VOICED;
    end else if (cfg.fold_halfwidth && item_point == CP_HW_SEMI) begin
      r = CP_MARK_SEMI;
    end

    main_res  = '{point: clamp(r), final_flag: item_final};
    flush_res = '{point: {{(CP_W-BASE_W){1'b0}}, held_base}, final_flag: 1'b0};

    pair = '0;
    if (composed) begin
      pair.count = 2'd1;
      pair.res0  = '{point: {{(CP_W-BASE_W){1'b0}}, comp}, final_flag: item_final};
    end else if (flush) begin
      pair.res0  = flush_res;
      pair.res1  = main_res;
      pair.count = hold_new ? 2'd1 : 2'd2;
    end else begin
      pair.res0  = main_res;
      pair.count = hold_new ? 2'd0 : 2'd1;
    end

    held_valid_next = held_valid;
    held_base_next  = held_base;
    if (fire) begin
      if (composed || !hold_new) begin
        held_valid_next = 1'b0;
        held_base_next  = '0;
      end else begin
        held_valid_next = 1'b1;
        held_base_next  = cfg.compose_only ? item_point[BASE_W-1:0] : wide;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_base  <= '0;
    end else begin
      held_valid <= held_valid_next;
      held_base  <= held_base_next;
    end
  end

  `ASSERT_HOLDS(a_held_nonzero, clk, rst, !held_valid || held_base != '0, "held base is zero")
  `ASSERT_NEXT(a_final_clears, clk, rst, fire && item_final, !held_valid, "base held past final")

endmodule

`default_nettype wire

### sv/jtwf_res_fifo.sv
`default_nettype none
`include "assert_macros.svh"

module jtwf_res_fifo #(
  parameter int DEPTH = jtwf_pkg::RES_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire jtwf_pkg::res_pair_t       pair,
  output logic                           room,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [jtwf_pkg::CP_W-1:0]      out_point,
  output logic                           out_final
);
  import jtwf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic [PW-1:0] wnext;
  logic [PW-1:0] wnext2;
  logic [PW-1:0] rnext;
  logic [1:0]    push_n;
  logic          pop;

  function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign push_n    = push ? pair.count : 2'd0;
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign room      = count <= CW'(DEPTH - 2);
  assign wnext     = step(wptr);
  assign wnext2    = step(wnext);
  assign rnext     = step(rptr);
  assign out_point = mem[rptr].point;
  assign out_final = mem[rptr].final_flag;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wptr] <= pair.res0;
    end
    if (push_n == 2'd2) begin
      mem[wnext] <= pair.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_n == 2'd1) begin
        wptr <= wnext;
      end else if (push_n == 2'd2) begin
        wptr <= wnext2;
      end
      if (pop) begin
        rptr <= rnext;
      end
      count <= count + CW'(push_n) - CW'(pop);
    end
  end

  `ASSERT_HOLDS(a_count_bound, clk, rst, count <= CW'(DEPTH), "result queue overflow")
  `ASSERT_NEXT(a_fill_shows, clk, rst, push_n != 2'd0 && count == '0, out_valid, "written beat not shown")

endmodule

`default_nettype wire

### sv/japanese_text_width_fold_top.sv
// channel   dir  signals                        payload
// s_axis    in   tvalid tready tdata tlast      tdata[20:0] code_point, tlast final_item
// m_axis    out  tvalid tready tdata tlast      tdata[20:0] folded_point, tlast final_result
// cfg       in   valid ready index data         index 0..2 register, data[0] value
//
// One input beat per cycle when the result queue has room for two results.
// An accepted beat is registered in the input stage, then its results are queued; a
// beat that flushes a held base and emits its own result queues two results.
// Reset clears the held base, empties the result queue and restores register defaults.
// A stalled m_axis fills the result queue, which then holds s_axis_tready low.
`default_nettype none

module japanese_text_width_fold_top #(
  parameter int RES_DEPTH = jtwf_pkg::RES_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // code_point[20:0], zeros[23:21]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // folded_point[20:0], zeros[23:21]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_data
);
  import jtwf_pkg::*;

  cfg_t            cfg;
  logic            item_valid;
  logic [CP_W-1:0] item_point;
  logic            item_final;
  logic            room;
  logic            fire;
  res_pair_t       pair;
  logic [CP_W-1:0] out_point;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fold_digits    <= 1'b1;
      cfg.fold_halfwidth <= 1'b1;
      cfg.compose_only   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FOLD_DIGITS:    cfg.fold_digits    <= cfg_data;
        REG_FOLD_HALFWIDTH: cfg.fold_halfwidth <= cfg_data;
        REG_COMPOSE_ONLY:   cfg.compose_only   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fire = item_valid && room;

  jtwf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_point   (s_axis_tdata[CP_W-1:0]),
    .in_final   (s_axis_tlast),
    .take       (fire),
    .item_valid (item_valid),
    .item_point (item_point),
    .item_final (item_final)
  );

  jtwf_fold u_fold (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_point (item_point),
    .item_final (item_final),
    .fire       (fire),
    .pair       (pair)
  );

  jtwf_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .pair      (pair),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_point (out_point),
    .out_final (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_point};

endmodule

`default_nettype wire
